FILE: rtl/topt_pkg.sv
// Shared types and constants for the 2-opt neighbor generator.
// Used by topt_pair_unit and two_opt_neighbour_generator; depends on nothing.
`timescale 1ns / 1ps

package topt_pkg;

    // Fixed field widths
    localparam int CITY_W   = 6;
    localparam int LEN_W    = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Default store depth
    localparam int MAX_CITIES_DEF = 64;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT_PAIR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_VALUE_PAIR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NEIGHBOR  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Requests into the pair enumerator
    typedef struct packed {
        logic              restart;
        logic              advance;
        logic [CITY_W-1:0] start_idx;
    } pair_req_t;

    // Status back from the pair enumerator
    typedef struct packed {
        logic              done;
        logic              was_exhausted;
        logic [CITY_W-1:0] first;
        logic [CITY_W-1:0] second;
    } pair_stat_t;

endpackage

FILE: rtl/topt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module topt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/topt_pair_unit.sv
// Index pair enumerator: restart, advance with wrap, exhaustion tracking.
// Depends on topt_pkg. The wrap reduction subtracts one step per cycle.
`timescale 1ns / 1ps

module topt_pair_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [topt_pkg::LEN_W-1:0]    len,
    input  topt_pkg::pair_req_t           req,
    output topt_pkg::pair_stat_t          stat
);
    import topt_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_MOD, P_CHK} pstate_t;

    pstate_t           state_reg;
    logic [CITY_W-1:0] start_reg;
    logic [CITY_W-1:0] first_reg;
    logic [CITY_W-1:0] second_reg;
    logic              exh_reg;
    logic              was_exh_reg;
    logic [LEN_W-1:0]  mod_reg;

    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  len_m2;
    logic [CITY_W-1:0] sidx_clamped;

    assign len_m1 = len - LEN_W'(1);
    assign len_m2 = len - LEN_W'(2);

    // Restart index is clamped to at most len - 2, the first index of the last pair
    assign sidx_clamped = ({1'b0, req.start_idx} > len_m2) ? len_m2[CITY_W-1:0]
                                                          : req.start_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= P_IDLE;
            start_reg   <= '0;
            first_reg   <= '0;
            second_reg  <= CITY_W'(1);
            exh_reg     <= 1'b0;
            was_exh_reg <= 1'b0;
            mod_reg     <= '0;
        end else begin
            case (state_reg)
                P_IDLE: begin
                    if (req.restart) begin
                        start_reg  <= sidx_clamped;
                        first_reg  <= sidx_clamped;
                        second_reg <= sidx_clamped + CITY_W'(1);
                        exh_reg    <= 1'b0;
                    end else if (req.advance) begin
                        was_exh_reg <= exh_reg;
                        if ({1'b0, second_reg} >= len_m1) begin
                            // wrap: first = (first + 1) mod (len - 1)
                            mod_reg   <= {1'b0, first_reg} + LEN_W'(1);
                            state_reg <= P_MOD;
                        end else begin
                            second_reg <= second_reg + CITY_W'(1);
                            state_reg  <= P_CHK;
                        end
                    end
                end
                P_MOD: begin
                    if (mod_reg >= len_m1) begin
                        mod_reg <= mod_reg - len_m1;
                    end else begin
                        first_reg  <= mod_reg[CITY_W-1:0];
                        second_reg <= mod_reg[CITY_W-1:0] + CITY_W'(1);
                        state_reg  <= P_CHK;
                    end
                end
                P_CHK: begin
                    // back at the start pair marks the run exhausted
                    if (first_reg == start_reg &&
                        {1'b0, second_reg} == {1'b0, start_reg} + LEN_W'(1)) begin
                        exh_reg <= 1'b1;
                    end
                    state_reg <= P_IDLE;
                end
                default: begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign stat.done          = (state_reg == P_CHK);
    assign stat.was_exhausted = was_exh_reg;
    assign stat.first         = first_reg;
    assign stat.second        = second_reg;

endmodule

FILE: rtl/two_opt_neighbour_generator.sv
// Top level of the 2-opt neighbor generator: tour load, city search, emission.
// Depends on topt_pkg, topt_ram and topt_pair_unit.
//
//   channel  dir  handshake          tdata (low bit up)                    side
//   s_       in   s_tvalid/s_tready  city, start_index, first/second_city  tuser=command
//   m_       out  m_tvalid/m_tready  city_res, segment_start, segment_end  tuser=status
//   cfg_     in   cfg_wen            tour_length                           -
//
// A load word writes one tour element into the store. A pair advance runs through
// the pair unit's P_CHK state, after P_MOD when it wraps to the next row; the wrap
// reduction in P_MOD needs one subtraction when the wrap returns to the first row,
// more for a pair left over from a longer tour. A city search streams the tour
// store through its read port and then orders the segment ends in S_SDONE.
// Each neighbor word passes through store read, output load and handshake, and
// waits out any stall on m_tready; input is taken only while no run is in progress.
// Reset clears control state; the tour store holds garbage until loaded.
`timescale 1ns / 1ps

module two_opt_neighbour_generator #(
    parameter int MAX_CITIES = topt_pkg::MAX_CITIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config
    input  logic                             cfg_wen,
    input  logic [topt_pkg::LEN_W-1:0]       cfg_wdata,   // tour_length
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,     // city, start_index, first_city, second_city
    input  logic [topt_pkg::CMD_W-1:0]       s_tuser,     // command
    input  logic                             s_tlast,     // last_element
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,     // city_res, segment_start, segment_end, 6'b0
    output logic [topt_pkg::STATUS_W-1:0]    m_tuser,     // status
    output logic                             m_tlast      // last_of_run
);
    import topt_pkg::*;

    localparam int AW = $clog2(MAX_CITIES);

    typedef enum logic [2:0] {
        S_IDLE, S_PAIR, S_SRCH, S_SDONE, S_EMIT_RD, S_EMIT_LD, S_OUT
    } state_t;

    state_t              state_reg;
    logic [LEN_W-1:0]    tlen_reg;
    logic [LEN_W-1:0]    load_pos_reg;
    logic [LEN_W-1:0]    k_reg;
    logic [LEN_W-1:0]    scan_reg;
    logic [LEN_W-1:0]    pend_k_reg;
    logic                pend_valid_reg;
    logic                fa_reg, fb_reg;
    logic [CITY_W-1:0]   ia_reg, ib_reg;
    logic [CITY_W-1:0]   c1_reg, c2_reg;
    logic [CITY_W-1:0]   lo_reg, hi_reg;
    logic                m_tvalid_reg;
    logic [CITY_W-1:0]   out_city_reg, out_lo_reg, out_hi_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic [LEN_W-1:0]    len_eff;
    logic                s_acc;
    logic [CITY_W-1:0]   in_city, in_sidx, in_c1, in_c2;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [CITY_W-1:0]   ram_rdata;
    logic [LEN_W-1:0]    src_idx;
    pair_req_t           pair_req;
    pair_stat_t          pair_stat;

    // Input unpacking
    assign in_city = s_tdata[5:0];
    assign in_sidx = s_tdata[11:6];
    assign in_c1   = s_tdata[17:12];
    assign in_c2   = s_tdata[23:18];

    // Clamp the configured length into [3, MAX_CITIES]
    always_comb begin
        if (tlen_reg < LEN_W'(3)) begin
            len_eff = LEN_W'(3);
        end else if (tlen_reg > LEN_W'(MAX_CITIES)) begin
            len_eff = LEN_W'(MAX_CITIES);
        end else begin
            len_eff = tlen_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Store write: one element per load word while positions remain
    assign ram_we    = s_acc && (s_tuser == CMD_NEXT_PAIR || s_tuser == CMD_VALUE_PAIR) &&
                       (load_pos_reg < len_eff);
    assign ram_waddr = load_pos_reg[AW-1:0];

    // Read address: scan during search; during emission, k reversed within [lo, hi] and k itself elsewhere
    always_comb begin
        if (k_reg >= {1'b0, lo_reg} && k_reg <= {1'b0, hi_reg}) begin
            src_idx = {1'b0, lo_reg} + {1'b0, hi_reg} - k_reg;
        end else begin
            src_idx = k_reg;
        end
    end
    assign ram_raddr = (state_reg == S_SRCH) ? scan_reg[AW-1:0] : src_idx[AW-1:0];

    topt_ram #(
        .WIDTH (CITY_W),
        .DEPTH (MAX_CITIES)
    ) u_tour_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_city),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pair enumerator requests
    assign pair_req.restart   = s_acc && (s_tuser == CMD_RESTART);
    assign pair_req.advance   = s_acc && (s_tuser == CMD_NEXT_PAIR) && s_tlast;
    assign pair_req.start_idx = in_sidx;

    topt_pair_unit u_pair (
        .aclk    (aclk),
        .aresetn (aresetn),
        .len     (len_eff),
        .req     (pair_req),
        .stat    (pair_stat)
    );

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlen_reg <= LEN_W'(MAX_CITIES_DEF);
        end else if (cfg_wen) begin
            tlen_reg <= cfg_wdata;
        end
    end

    // Main sequencer: load, pair advance, search, emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            load_pos_reg   <= '0;
            k_reg          <= '0;
            scan_reg       <= '0;
            pend_k_reg     <= '0;
            pend_valid_reg <= 1'b0;
            fa_reg         <= 1'b0;
            fb_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser == CMD_RESTART) begin
                            load_pos_reg <= '0;
                        end else if (s_tuser == CMD_NEXT_PAIR ||
                                     s_tuser == CMD_VALUE_PAIR) begin
                            if (s_tlast) begin
                                load_pos_reg <= '0;
                                k_reg        <= '0;
                                if (s_tuser == CMD_NEXT_PAIR) begin
                                    state_reg <= S_PAIR;
                                end else begin
                                    c1_reg         <= in_c1;
                                    c2_reg         <= in_c2;
                                    scan_reg       <= '0;
                                    pend_valid_reg <= 1'b0;
                                    fa_reg         <= 1'b0;
                                    fb_reg         <= 1'b0;
                                    state_reg      <= S_SRCH;
                                end
                            end else if (load_pos_reg < len_eff) begin
                                load_pos_reg <= load_pos_reg + LEN_W'(1);
                            end
                        end
                    end
                end
                S_PAIR: begin
                    if (pair_stat.done) begin
                        if (pair_stat.was_exhausted) begin
                            out_city_reg   <= '0;
                            out_lo_reg     <= '0;
                            out_hi_reg     <= '0;
                            out_status_reg <= ST_EXHAUSTED;
                            out_last_reg   <= 1'b1;
                            m_tvalid_reg   <= 1'b1;
                            state_reg      <= S_OUT;
                        end else begin
                            lo_reg    <= pair_stat.first;
                            hi_reg    <= pair_stat.second;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_SRCH: begin
                    // issue one read per cycle, compare the previous one
                    if (scan_reg < len_eff) begin
                        scan_reg       <= scan_reg + LEN_W'(1);
                        pend_valid_reg <= 1'b1;
                        pend_k_reg     <= scan_reg;
                    end else begin
                        pend_valid_reg <= 1'b0;
                    end
                    if (pend_valid_reg) begin
                        if (!fa_reg && ram_rdata == c1_reg) begin
                            fa_reg <= 1'b1;
                            ia_reg <= pend_k_reg[CITY_W-1:0];
                        end
                        if (!fb_reg && ram_rdata == c2_reg) begin
                            fb_reg <= 1'b1;
                            ib_reg <= pend_k_reg[CITY_W-1:0];
                        end
                        if (pend_k_reg == len_eff - LEN_W'(1)) begin
                            state_reg <= S_SDONE;
                        end
                    end
                end
                S_SDONE: begin
                    if (!(fa_reg && fb_reg)) begin
                        out_city_reg   <= '0;
                        out_lo_reg     <= '0;
                        out_hi_reg     <= '0;
                        out_status_reg <= ST_NOT_FOUND;
                        out_last_reg   <= 1'b1;
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= S_OUT;
                    end else begin
                        lo_reg    <= (ia_reg < ib_reg) ? ia_reg : ib_reg;
                        hi_reg    <= (ia_reg < ib_reg) ? ib_reg : ia_reg;
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    // read address for word k is presented this cycle
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    out_city_reg   <= ram_rdata;
                    out_lo_reg     <= lo_reg;
                    out_hi_reg     <= hi_reg;
                    out_status_reg <= ST_NEIGHBOR;
                    out_last_reg   <= (k_reg == len_eff - LEN_W'(1));
                    m_tvalid_reg   <= 1'b1;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + LEN_W'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output word
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_hi_reg, out_lo_reg, out_city_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule
